[design/e2q_pkg.sv]
package e2q_pkg;

    localparam int CORDIC_STAGES = 14;
    localparam int ATAN_ENTRIES  = 24;

    localparam int AW = 16;
    localparam int QW = 16;
    localparam int XW = 32;
    localparam int ZW = 33;
    localparam int HW = 34;
    localparam int PW = 64;

    localparam logic signed [XW-1:0] Q30_K       = 32'sd652032874;
    localparam logic signed [HW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [HW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [PW-1:0] RND_Q30     = 64'sd536870912;
    localparam logic signed [PW:0]   RND_Q14     = 65'sd35184372088832;
    localparam logic signed [18:0]   Q14_ONE     = 19'sd16384;

    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
        logic signed [QW-1:0] w;
    } t_quat;

    function automatic logic [XW-1:0] atan_q30(input int idx);
        logic [XW-1:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Rounds a Q60 sum to Q14 (halves toward plus infinity) and clamps to plus or minus one.
    function automatic logic signed [QW-1:0] q60_to_q14(input logic signed [PW:0] s);
        logic signed [PW:0] r;
        logic signed [18:0] v;
        logic signed [QW-1:0] q;
        r = s + RND_Q14;
        v = r[PW:46];
        if (v > Q14_ONE) begin
            q = 16'sd16384;
        end else if (v < -Q14_ONE) begin
            q = -16'sd16384;
        end else begin
            q = v[QW-1:0];
        end
        return q;
    endfunction

endpackage

[design/e2q_if.sv]
interface e2q_angle_if;
    logic                                valid;
    logic                                ready;
    logic signed [e2q_pkg::AW-1:0]       pitch_angle;
    logic signed [e2q_pkg::AW-1:0]       yaw_angle;
    logic signed [e2q_pkg::AW-1:0]       roll_angle;

    modport source(output valid, output pitch_angle, output yaw_angle, output roll_angle,
                   input ready);
    modport sink(input valid, input pitch_angle, input yaw_angle, input roll_angle,
                 output ready);
endinterface

interface e2q_quat_if;
    logic                                valid;
    logic                                ready;
    logic signed [e2q_pkg::QW-1:0]       quat_x;
    logic signed [e2q_pkg::QW-1:0]       quat_y;
    logic signed [e2q_pkg::QW-1:0]       quat_z;
    logic signed [e2q_pkg::QW-1:0]       quat_w;

    modport source(output valid, output quat_x, output quat_y, output quat_z, output quat_w,
                   input ready);
    modport sink(input valid, input quat_x, input quat_y, input quat_z, input quat_w,
                 output ready);
endinterface

[design/e2q_cordic.sv]
module e2q_cordic #(
    parameter int STAGES = e2q_pkg::CORDIC_STAGES
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [e2q_pkg::AW-1:0]  i_angle,
    output logic signed [e2q_pkg::XW-1:0]  o_sin,
    output logic signed [e2q_pkg::XW-1:0]  o_cos
);

    localparam int NIT = (STAGES < e2q_pkg::ATAN_ENTRIES) ? STAGES : e2q_pkg::ATAN_ENTRIES;
    localparam int XW  = e2q_pkg::XW;
    localparam int ZW  = e2q_pkg::ZW;
    localparam int HW  = e2q_pkg::HW;

    logic signed [XW-1:0] r_x   [0:NIT];
    logic signed [XW-1:0] r_y   [0:NIT];
    logic signed [ZW-1:0] r_z   [0:NIT];
    logic                 r_neg [0:NIT];
    logic signed [XW-1:0] r_sin;
    logic signed [XW-1:0] r_cos;

    logic signed [HW-1:0] w_half;
    logic signed [HW-1:0] n_z;
    logic                 n_neg;

    // The half angle in Q30 is the raw Q3.12 value shifted up by 17.
    assign w_half = {i_angle[e2q_pkg::AW-1], i_angle, 17'b0};

    always_comb begin
        n_z   = w_half;
        n_neg = 1'b0;
        if (w_half > e2q_pkg::Q30_HALF_PI) begin
            n_z   = w_half - e2q_pkg::Q30_PI;
            n_neg = 1'b1;
        end else if (w_half < -e2q_pkg::Q30_HALF_PI) begin
            n_z   = w_half + e2q_pkg::Q30_PI;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= e2q_pkg::Q30_K;
            r_y[0]   <= '0;
            r_z[0]   <= n_z[ZW-1:0];
            r_neg[0] <= n_neg;
        end
    end

    for (genvar k = 0; k < NIT; k++) begin : g_stage
        logic signed [ZW-1:0] w_atan;
        assign w_atan = $signed({1'b0, e2q_pkg::atan_q30(k)});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k+1] <= r_neg[k];
                if (!r_z[k][ZW-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - w_atan;
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + w_atan;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_neg[NIT] ? -r_x[NIT] : r_x[NIT];
            r_sin <= r_neg[NIT] ? -r_y[NIT] : r_y[NIT];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

[design/euler_to_quaternion.sv]
// Channel   Dir  Fields                                 Format
// i_angle   in   pitch_angle, yaw_angle, roll_angle     signed Q3.12 radians
// o_quat    out  quat_x, quat_y, quat_z, quat_w         signed Q1.14, clamped to +-1
//
// One word is accepted per cycle while the skid register is empty; its result passes
// through the CORDIC chain with its input and output registers (at most 24 CORDIC
// stages run), five product stages and the output register.
// Reset clears only the valid bits and the output and skid flags.
// The pipeline advances whenever the skid register is empty, so a stalled output
// holds one result in the output register and one in the skid register.
module euler_to_quaternion #(
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    e2q_angle_if.sink        i_angle,
    e2q_quat_if.source       o_quat
);

    localparam int NIT   = (CORDIC_STAGES < e2q_pkg::ATAN_ENTRIES) ?
                           CORDIC_STAGES : e2q_pkg::ATAN_ENTRIES;
    localparam int DEPTH = NIT + 7;
    localparam int XW    = e2q_pkg::XW;
    localparam int PW    = e2q_pkg::PW;

    logic w_en;
    logic [DEPTH-1:0] r_pv;

    logic signed [XW-1:0] w_sp, w_cp, w_sy, w_cy, w_sr, w_cr;

    logic signed [PW-1:0] r_spcy, r_cpsy, r_cpcy, r_spsy;
    logic signed [XW-1:0] r_sr1, r_cr1, r_sr2, r_cr2;
    logic signed [XW-1:0] r_a_spcy, r_a_cpsy, r_a_cpcy, r_a_spsy;
    logic signed [PW-1:0] w_rnd_spcy, w_rnd_cpsy, w_rnd_cpcy, w_rnd_spsy;
    logic signed [PW-1:0] r_t [0:7];
    logic signed [PW:0]   r_sx, r_sy, r_sz, r_sw;
    e2q_pkg::t_quat       r_q;

    e2q_pkg::t_quat r_out, n_out, r_skid, n_skid;
    logic           r_out_v, n_out_v, r_skid_v, n_skid_v;

    assign w_en = !r_skid_v;
    assign i_angle.ready = w_en;

    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle.pitch_angle), .o_sin(w_sp), .o_cos(w_cp)
    );
    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle.yaw_angle), .o_sin(w_sy), .o_cos(w_cy)
    );
    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle.roll_angle), .o_sin(w_sr), .o_cos(w_cr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (w_en) begin
            r_pv <= {r_pv[DEPTH-2:0], i_angle.valid};
        end
    end

    assign w_rnd_spcy = r_spcy + e2q_pkg::RND_Q30;
    assign w_rnd_cpsy = r_cpsy + e2q_pkg::RND_Q30;
    assign w_rnd_cpcy = r_cpcy + e2q_pkg::RND_Q30;
    assign w_rnd_spsy = r_spsy + e2q_pkg::RND_Q30;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_spcy <= w_sp * w_cy;
            r_cpsy <= w_cp * w_sy;
            r_cpcy <= w_cp * w_cy;
            r_spsy <= w_sp * w_sy;
            r_sr1  <= w_sr;
            r_cr1  <= w_cr;

            r_a_spcy <= w_rnd_spcy[61:30];
            r_a_cpsy <= w_rnd_cpsy[61:30];
            r_a_cpcy <= w_rnd_cpcy[61:30];
            r_a_spsy <= w_rnd_spsy[61:30];
            r_sr2    <= r_sr1;
            r_cr2    <= r_cr1;

            r_t[0] <= r_a_spcy * r_cr2;
            r_t[1] <= r_a_cpsy * r_sr2;
            r_t[2] <= r_a_cpsy * r_cr2;
            r_t[3] <= r_a_spcy * r_sr2;
            r_t[4] <= r_a_cpcy * r_sr2;
            r_t[5] <= r_a_spsy * r_cr2;
            r_t[6] <= r_a_cpcy * r_cr2;
            r_t[7] <= r_a_spsy * r_sr2;

            r_sx <= {r_t[0][PW-1], r_t[0]} - {r_t[1][PW-1], r_t[1]};
            r_sy <= {r_t[2][PW-1], r_t[2]} + {r_t[3][PW-1], r_t[3]};
            r_sz <= {r_t[4][PW-1], r_t[4]} - {r_t[5][PW-1], r_t[5]};
            r_sw <= {r_t[6][PW-1], r_t[6]} + {r_t[7][PW-1], r_t[7]};

            r_q.x <= e2q_pkg::q60_to_q14(r_sx);
            r_q.y <= e2q_pkg::q60_to_q14(r_sy);
            r_q.z <= e2q_pkg::q60_to_q14(r_sz);
            r_q.w <= e2q_pkg::q60_to_q14(r_sw);
        end
    end

    always_comb begin
        n_out    = r_out;
        n_out_v  = r_out_v;
        n_skid   = r_skid;
        n_skid_v = r_skid_v;
        if (r_skid_v) begin
            if (o_quat.ready) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (!r_out_v || o_quat.ready) begin
            n_out   = r_q;
            n_out_v = r_pv[DEPTH-1];
        end else if (r_pv[DEPTH-1]) begin
            n_skid   = r_q;
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_quat.valid  = r_out_v;
    assign o_quat.quat_x = r_out.x;
    assign o_quat.quat_y = r_out.y;
    assign o_quat.quat_z = r_out.z;
    assign o_quat.quat_w = r_out.w;

endmodule

[design/e2q_checker.sv]
module e2q_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic signed [e2q_pkg::QW-1:0]  i_quat_x,
    input logic signed [e2q_pkg::QW-1:0]  i_quat_y,
    input logic signed [e2q_pkg::QW-1:0]  i_quat_z,
    input logic signed [e2q_pkg::QW-1:0]  i_quat_w
);

    // A word held back by the sink must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_quat_x)
            && $stable(i_quat_y) && $stable(i_quat_z) && $stable(i_quat_w))
        else $error("quaternion word changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_quat_x <= 16'sd16384 && i_quat_x >= -16'sd16384
            && i_quat_y <= 16'sd16384 && i_quat_y >= -16'sd16384
            && i_quat_z <= 16'sd16384 && i_quat_z >= -16'sd16384
            && i_quat_w <= 16'sd16384 && i_quat_w >= -16'sd16384)
        else $error("quaternion part beyond plus or minus one");

    // The input side may only stall while a finished word waits at the output.
    a_stall_cause: assert property (@(posedge i_clk)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending output word");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_angle.ready),
    .i_out_valid (o_quat.valid),
    .i_out_ready (o_quat.ready),
    .i_quat_x    (o_quat.quat_x),
    .i_quat_y    (o_quat.quat_y),
    .i_quat_z    (o_quat.quat_z),
    .i_quat_w    (o_quat.quat_w)
);

[bench/euler_to_quaternion_tb.sv]
module euler_to_quaternion_tb;

    localparam int AW      = e2q_pkg::AW;
    localparam int QW      = e2q_pkg::QW;
    localparam int STAGES  = e2q_pkg::CORDIC_STAGES;
    localparam int LATENCY = STAGES + 8;

    localparam longint CYCLE_LIMIT = 200000;
    localparam longint GAIN_Q30    = 652032874;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 1686629713;
    localparam longint ONE_Q14     = 16384;

    localparam longint ATAN_Q30_TAB [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    typedef struct packed {
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] yaw;
        logic signed [AW-1:0] roll;
    } t_euler;

    logic clk;
    logic rst_n;

    e2q_angle_if angle_if();
    e2q_quat_if  quat_if();

    euler_to_quaternion dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_angle (angle_if),
        .o_quat  (quat_if)
    );

    e2q_pkg::t_quat pending_quats[$];
    e2q_pkg::t_quat want_quat;

    int     words_sent    = 0;
    int     quats_checked = 0;
    int     mismatches    = 0;
    int     in_stalls     = 0;
    int     burst_left    = 0;
    int     hold_token    = 0;
    int     hold_len      = 0;
    int     hold_seen     = 0;
    int     hold_left     = 0;
    int     rx_cycle      = 0;
    int     rx_mode       = 0;
    longint cycle_count   = 0;

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void half_sincos(input logic signed [AW-1:0] ang,
                                        output longint sin_q30, output longint cos_q30);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(ang) * 131072;
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_Q30) begin
            z -= PI_Q30;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ATAN_Q30_TAB[i];
            end else begin
                x += dx;
                y -= dy;
                z += ATAN_Q30_TAB[i];
            end
        end
        cos_q30 = flip ? -x : x;
        sin_q30 = flip ? -y : y;
    endfunction

    function automatic longint triple_q60(input longint a, input longint b, input longint c);
        return ((a * b + 64'sd536870912) >>> 30) * c;
    endfunction

    function automatic logic signed [QW-1:0] q14_from_q60(input longint q60);
        longint v;
        v = (q60 + (longint'(1) <<< 45)) >>> 46;
        if (v > ONE_Q14) begin
            v = ONE_Q14;
        end
        if (v < -ONE_Q14) begin
            v = -ONE_Q14;
        end
        return QW'(v);
    endfunction

    function automatic e2q_pkg::t_quat quat_from_euler(input t_euler e);
        longint sp, cp, sy, cy, sr, cr;
        e2q_pkg::t_quat q;
        half_sincos(e.pitch, sp, cp);
        half_sincos(e.yaw, sy, cy);
        half_sincos(e.roll, sr, cr);
        q.x = q14_from_q60(triple_q60(sp, cy, cr) - triple_q60(cp, sy, sr));
        q.y = q14_from_q60(triple_q60(cp, sy, cr) + triple_q60(sp, cy, sr));
        q.z = q14_from_q60(triple_q60(cp, cy, sr) - triple_q60(sp, sy, cr));
        q.w = q14_from_q60(triple_q60(cp, cy, cr) + triple_q60(sp, sy, sr));
        return q;
    endfunction

    function automatic t_euler rand_euler(input bit principal);
        t_euler e;
        if (principal) begin
            e.pitch = AW'(int'($urandom_range(0, 25736)) - 12868);
            e.yaw   = AW'(int'($urandom_range(0, 25736)) - 12868);
            e.roll  = AW'(int'($urandom_range(0, 25736)) - 12868);
        end else begin
            e.pitch = AW'($urandom());
            e.yaw   = AW'($urandom());
            e.roll  = AW'($urandom());
        end
        return e;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_angles(input t_euler a);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                angle_if.valid       <= 1'b0;
                angle_if.pitch_angle <= AW'($urandom());
                angle_if.yaw_angle   <= AW'($urandom());
                angle_if.roll_angle  <= AW'($urandom());
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        angle_if.valid       <= 1'b1;
        angle_if.pitch_angle <= a.pitch;
        angle_if.yaw_angle   <= a.yaw;
        angle_if.roll_angle  <= a.roll;
        @(posedge clk);
        while (!angle_if.ready) @(posedge clk);
        pending_quats.push_back(quat_from_euler(a));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic test_directed();
        int dir_angles [21][3];
        t_euler e;
        dir_angles = '{
            '{0, 0, 0}, '{32767, 32767, 32767}, '{-32768, -32768, -32768},
            '{32767, -32768, 0}, '{12867, 0, 0}, '{12868, 0, 0},
            '{-12867, 0, 0}, '{-12868, 0, 0}, '{0, 12868, -12868},
            '{0, -12867, 12867}, '{12868, 12868, 12868}, '{-12868, -12868, -12868},
            '{25736, 0, 0}, '{6434, 0, 0}, '{0, 6434, 0},
            '{0, 0, 6434}, '{6434, 6434, 6434}, '{-6434, 3217, -3217},
            '{1, -1, 1}, '{-1, 1, -1}, '{21845, -21846, 32767}
        };
        for (int k = 0; k < 21; k++) begin
            e.pitch = AW'(dir_angles[k][0]);
            e.yaw   = AW'(dir_angles[k][1]);
            e.roll  = AW'(dir_angles[k][2]);
            send_angles(e);
        end
    endtask

    task automatic test_full_range(input int count);
        repeat (count) send_angles(rand_euler(1'b0));
    endtask

    task automatic test_principal_range(input int count);
        repeat (count) send_angles(rand_euler(1'b1));
    endtask

    // The output side holds off long enough that the pipeline and skid fill up.
    task automatic test_output_hold();
        hold_len   <= 400;
        hold_token <= hold_token + 1;
        repeat (80) send_angles(rand_euler(1'b1));
    endtask

    initial begin
        quat_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 48 == 0) begin
                rx_mode = $urandom_range(0, 3);
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                quat_if.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: begin
                        quat_if.ready <= 1'b1;
                    end
                    1: begin
                        quat_if.ready <= ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        quat_if.ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        quat_if.ready <= ((rx_cycle / 2) % 2 == 0);
                    end
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && quat_if.valid && quat_if.ready) begin
            if (pending_quats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected quaternion word: x=%0d y=%0d z=%0d w=%0d",
                             quat_if.quat_x, quat_if.quat_y, quat_if.quat_z, quat_if.quat_w);
                end
            end else begin
                want_quat = pending_quats.pop_front();
                quats_checked++;
                if (quat_if.quat_x !== want_quat.x || quat_if.quat_y !== want_quat.y ||
                    quat_if.quat_z !== want_quat.z || quat_if.quat_w !== want_quat.w) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Quaternion %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 quats_checked, want_quat.x, want_quat.y, want_quat.z,
                                 want_quat.w, quat_if.quat_x, quat_if.quat_y,
                                 quat_if.quat_z, quat_if.quat_w);
                    end
                end
            end
        end
        if (rst_n && angle_if.valid && !angle_if.ready) begin
            in_stalls++;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out with %0d quaternions outstanding.", pending_quats.size());
            $display("** euler_to_quaternion: FAILED **");
            $finish;
        end
    end

    initial begin
        rst_n                = 1'b0;
        angle_if.valid       = 1'b0;
        angle_if.pitch_angle = '0;
        angle_if.yaw_angle   = '0;
        angle_if.roll_angle  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_range(700);
        test_principal_range(250);
        test_output_hold();

        angle_if.valid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge clk);
        repeat (LATENCY + 16) @(posedge clk);

        $display("Sent %0d angle words: corners, fold edges and random angles.", words_sent);
        $display("Checked %0d quaternions under random stalls and a long hold-off.",
                 quats_checked);
        $display("Input stalled for %0d cycles.", in_stalls);
        if (mismatches == 0 && pending_quats.size() == 0) begin
            $display("** euler_to_quaternion: PASSED **");
        end else begin
            $display("** euler_to_quaternion: FAILED **");
        end
        $finish;
    end

endmodule
